// ----- rtl/subset_sum_count_table_defines.svh -----
// Assertion macros shared by the subset-sum count table RTL.
`ifndef SUBSET_SUM_COUNT_TABLE_DEFINES_SVH
`define SUBSET_SUM_COUNT_TABLE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SSCT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssct check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SSCT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssct check failed");

`endif

// ----- rtl/ssct_pkg.sv -----
// Types and constants shared by the subset-sum count table modules.
`default_nettype none

package ssct_pkg;

	// Table geometry.
	localparam int MAX_QUOTA  = 1024;
	localparam int COUNT_BITS = 64;
	localparam int ADDR_BITS  = $clog2(MAX_QUOTA);
	localparam int SUM_BITS   = $clog2(MAX_QUOTA + 1);

	// Fixed field widths.
	localparam int FIELD_BITS = 11;
	localparam int PADDR_BITS = 2;
	localparam int PDATA_BITS = 32;

	// Register addresses.
	localparam logic [PADDR_BITS-1:0] REG_QUOTA_ADDR = 2'd0;
	localparam logic [FIELD_BITS-1:0] QUOTA_RESET    = 11'd1;

	// Request codes.
	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_ADD   = 2'd1,
		REQ_READ  = 2'd2
	} req_code_t;

	// One request item.
	typedef struct packed {
		logic [1:0]            req_type;
		logic [FIELD_BITS-1:0] player_weight;
		logic [FIELD_BITS-1:0] sum_index;
	} req_t;

	// One result item.
	typedef struct packed {
		logic [COUNT_BITS-1:0] coalition_count;
		logic                  saturated;
	} rsp_t;

endpackage

`default_nettype wire

// ----- rtl/ssct_ram.sv -----
// Generic synchronous RAM with one write port and two registered read ports.
`default_nettype none

module ssct_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read ports, registered.
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

// ----- rtl/ssct_cfg.sv -----
// Configuration register bank holding the quota.
`default_nettype none

module ssct_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ssct_pkg::PADDR_BITS-1:0] paddr,
	input  wire logic [ssct_pkg::PDATA_BITS-1:0] pwdata,
	output logic      [ssct_pkg::PDATA_BITS-1:0] prdata,
	output logic                                 pready,
	output logic      [ssct_pkg::FIELD_BITS-1:0] quota
);
	import ssct_pkg::*;

	logic [FIELD_BITS-1:0] quota_q;
	logic                  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign quota  = quota_q;

	// Quota register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quota_q <= QUOTA_RESET;
		end else if (wr_en && paddr == REG_QUOTA_ADDR) begin
			quota_q <= pwdata[FIELD_BITS-1:0];
		end
	end

	// Read-back mux.
	always_comb begin
		prdata = '0;
		if (paddr == REG_QUOTA_ADDR) begin
			prdata = {{(PDATA_BITS-FIELD_BITS){1'b0}}, quota_q};
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ssct_ctrl.sv -----
// Sequencer that clears, updates and reads the count table held in RAM.
`default_nettype none

`include "subset_sum_count_table_defines.svh"

module ssct_ctrl (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [ssct_pkg::FIELD_BITS-1:0] quota,
	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire ssct_pkg::req_t                  req,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output ssct_pkg::rsp_t                       rsp
);
	import ssct_pkg::*;

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_ADD,
		S_DRAIN,
		S_RD
	} state_t;

	state_t                state_q;
	logic [ADDR_BITS-1:0]  clr_addr_q;
	logic [SUM_BITS-1:0]   s_q;
	logic [SUM_BITS-1:0]   w_q;
	logic [SUM_BITS-1:0]   rws_q;
	logic                  ovf_q;
	logic                  rd_zero_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	// Write-back stage of the update walk.
	logic                  wr_v_s1;
	logic [ADDR_BITS-1:0]  wr_addr_s1;
	logic                  base_s1;

	logic                  accept;
	logic [SUM_BITS-1:0]   w_in;
	logic [SUM_BITS:0]     rws_sum;
	logic [SUM_BITS-1:0]   rws_new;
	logic [SUM_BITS-1:0]   q_cap;
	logic [SUM_BITS-1:0]   upper;
	logic [SUM_BITS-1:0]   s_m1;
	logic [SUM_BITS-1:0]   s_mw1;
	logic [FIELD_BITS-1:0] idx_m1;
	logic                  idx_ok;

	logic                  ram_we;
	logic [ADDR_BITS-1:0]  ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [ADDR_BITS-1:0]  raddr_a;
	logic [ADDR_BITS-1:0]  raddr_b;
	logic [COUNT_BITS-1:0] rdata_a;
	logic [COUNT_BITS-1:0] rdata_b;
	logic [COUNT_BITS:0]   acc_sum;
	logic                  acc_carry;

	ssct_ram #(
		.DEPTH(MAX_QUOTA),
		.WIDTH(COUNT_BITS)
	) u_table (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	// Items are taken only when idle; a read also needs the result slot to free up.
	assign req_stall = (state_q != S_IDLE) ||
		(req.req_type == REQ_READ && rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Running sum and walk bound for an add request.
	always_comb begin
		w_in    = SUM_BITS'(req.player_weight);
		rws_sum = {1'b0, rws_q} + {1'b0, w_in};
		rws_new = (rws_sum > (SUM_BITS+1)'(MAX_QUOTA)) ? SUM_BITS'(MAX_QUOTA)
			: rws_sum[SUM_BITS-1:0];
		q_cap   = (SUM_BITS'(quota) > SUM_BITS'(MAX_QUOTA)) ? SUM_BITS'(MAX_QUOTA)
			: SUM_BITS'(quota);
		upper   = (rws_new < q_cap) ? rws_new : q_cap;
	end

	// Read addresses: entry s-1 and entry s-w-1 during a walk, else the read index.
	always_comb begin
		s_m1    = s_q - 1'b1;
		s_mw1   = s_q - w_q - 1'b1;
		idx_m1  = req.sum_index - 1'b1;
		idx_ok  = (req.sum_index != '0) && (req.sum_index <= FIELD_BITS'(MAX_QUOTA));
		raddr_b = s_mw1[ADDR_BITS-1:0];
		if (state_q == S_ADD) begin
			raddr_a = s_m1[ADDR_BITS-1:0];
		end else begin
			raddr_a = idx_m1[ADDR_BITS-1:0];
		end
	end

	// Saturating accumulate and the table write port.
	always_comb begin
		acc_sum   = {1'b0, rdata_a} + (base_s1 ? (COUNT_BITS+1)'(1) : {1'b0, rdata_b});
		acc_carry = acc_sum[COUNT_BITS];
		if (state_q == S_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = wr_v_s1;
			ram_waddr = wr_addr_s1;
			ram_wdata = acc_carry ? '1 : acc_sum[COUNT_BITS-1:0];
		end
	end

	// Sequencer state, walk pipeline and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_addr_q  <= '0;
			s_q         <= '0;
			w_q         <= '0;
			rws_q       <= '0;
			ovf_q       <= 1'b0;
			rd_zero_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			wr_v_s1     <= 1'b0;
			wr_addr_s1  <= '0;
			base_s1     <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (wr_v_s1 && acc_carry) begin
				ovf_q <= 1'b1;
			end
			wr_v_s1    <= 1'b0;
			wr_addr_s1 <= s_m1[ADDR_BITS-1:0];
			base_s1    <= (s_q == w_q);
			case (state_q)
				S_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_BITS'(MAX_QUOTA - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_CLEAR: begin
								rws_q      <= '0;
								ovf_q      <= 1'b0;
								clr_addr_q <= '0;
								state_q    <= S_CLR;
							end
							REQ_ADD: begin
								if (w_in != '0) begin
									rws_q <= rws_new;
									if (upper >= w_in) begin
										s_q     <= upper;
										w_q     <= w_in;
										state_q <= S_ADD;
									end
								end
							end
							REQ_READ: begin
								rd_zero_q <= !idx_ok;
								state_q   <= S_RD;
							end
							default: begin
							end
						endcase
					end
				end
				S_ADD: begin
					wr_v_s1 <= 1'b1;
					s_q     <= s_m1;
					if (s_q == w_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_IDLE;
				end
				S_RD: begin
					rsp_q.coalition_count <= rd_zero_q ? '0 : rdata_a;
					rsp_q.saturated       <= ovf_q;
					rsp_valid_q           <= 1'b1;
					state_q               <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A write-back only happens while a walk is running or draining.
	`SSCT_ASSERT_IMPL(a_wb_in_walk, wr_v_s1, (state_q == S_ADD || state_q == S_DRAIN))
	// The walk never reads the entry that is being written back.
	`SSCT_ASSERT_IMPL(a_no_rw_overlap, (state_q == S_ADD && wr_v_s1), (raddr_a != wr_addr_s1))
	// The result slot is free when read data lands.
	`SSCT_ASSERT_IMPL(a_slot_free, (state_q == S_RD), !rsp_valid_q)
	// A clear starts the sweep with the running sum and flag zeroed.
	`SSCT_ASSERT_NEXT(a_clear_starts, (accept && req.req_type == REQ_CLEAR),
		(state_q == S_CLR && rws_q == '0 && !ovf_q))

endmodule

`default_nettype wire

// ----- rtl/subset_sum_count_table.sv -----
// Top level of the subset-sum coalition count table.
`default_nettype none

// Counts, for each weight sum from 1 to the quota, the coalitions of the players
// added so far; the 1024 x 64-bit table lives in one RAM with one write port.
// After reset, and after each clear item, the table is swept to zero one entry
// per cycle, and no item is taken during the sweep (quota writes still are).
// An add item walks the sums from min(running sum, quota) down to the weight,
// one read-modify-write per cycle, then drains the last write-back; an add that
// changes no entry leaves the sequencer idle. A read item passes through a read
// state and its result sits in an output register, so later clears and adds
// proceed while the result waits to be taken; a further read waits until it
// has been taken. Counts saturate at all ones and set the saturated flag until
// the next clear.
module subset_sum_count_table (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ssct_pkg::PADDR_BITS-1:0] paddr,
	input  wire logic [ssct_pkg::PDATA_BITS-1:0] pwdata,
	output logic      [ssct_pkg::PDATA_BITS-1:0] prdata,
	output logic                                 pready,
	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire ssct_pkg::req_t                  req,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output ssct_pkg::rsp_t                       rsp
);
	import ssct_pkg::*;

	logic [FIELD_BITS-1:0] quota;

	// Register bank.
	ssct_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.quota  (quota)
	);

	// Table sequencer with its RAM.
	ssct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.quota    (quota),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire
